[rtl/core/ihcf_pkg.sv]
// ----------------------------------------------------------------------------
// ihcf_pkg
// Shared constants and types for the header and CR LF framer.
// ----------------------------------------------------------------------------
package ihcf_pkg;

    localparam int unsigned WIN_BYTES = 8;
    localparam int unsigned HDR_LEN   = 5;
    localparam int unsigned MIN_LINE  = 2;
    localparam int unsigned IDX_W     = 6;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // "+IPD,"
    localparam logic [7:0] HDR_PAT [HDR_LEN] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};

    typedef struct packed {
        logic header_hit;
        logic tail_crlf;
    } t_match;

    typedef struct packed {
        logic             frame_ok;
        logic             frame_full;
        logic [IDX_W-1:0] line_length;
        logic             header_seen;
        logic [IDX_W-1:0] write_index;
    } t_frame_res;

endpackage

[rtl/core/ihcf_cell.sv]
// ----------------------------------------------------------------------------
// ihcf_cell
// One byte of the receive window; loads its neighbour's byte on a shift.
// ----------------------------------------------------------------------------
module ihcf_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

[rtl/core/ihcf_frame.sv]
// ----------------------------------------------------------------------------
// ihcf_frame
// Frame position counter and header, line and full-frame decisions.
// ----------------------------------------------------------------------------
module ihcf_frame #(
    parameter int unsigned FRAME_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  ihcf_pkg::t_match    i_match,
    output ihcf_pkg::t_frame_res o_res
);
    import ihcf_pkg::*;

    localparam int unsigned PW = $clog2(FRAME_BYTES);
    localparam int unsigned CW = PW + 1;

    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      n_pos;
    logic [CW-1:0]      w_next;
    logic               w_hdr;
    logic               w_line;
    logic               w_full;
    logic [PW+IDX_W-1:0] w_wi_ext;
    logic [PW+IDX_W-1:0] w_len_ext;

    always_comb begin
        w_next = {1'b0, r_pos} + CW'(1);
        w_hdr  = i_match.header_hit && (w_next >= CW'(WIN_BYTES));
        // a header restarts the frame, so the line and full checks see nothing
        w_line = !w_hdr && i_match.tail_crlf && (w_next >= CW'(MIN_LINE))
                 && (w_next < CW'(FRAME_BYTES));
        w_full = !w_hdr && (w_next == CW'(FRAME_BYTES));

        if (w_hdr || w_line || w_full) begin
            n_pos = '0;
        end else begin
            n_pos = w_next[PW-1:0];
        end

        w_wi_ext  = {{IDX_W{1'b0}}, r_pos};
        w_len_ext = w_line ? {{IDX_W{1'b0}}, w_next[PW-1:0]} : '0;

        o_res.write_index = w_wi_ext[IDX_W-1:0];
        o_res.header_seen = w_hdr;
        o_res.line_length = w_len_ext[IDX_W-1:0];
        o_res.frame_full  = w_full;
        o_res.frame_ok    = w_full && i_match.tail_crlf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

endmodule

[rtl/core/ipd_header_and_crlf_framer.sv]
// ----------------------------------------------------------------------------
// ipd_header_and_crlf_framer
// Frames received bytes on "+IPD," headers, CR LF line ends and full frames.
// ----------------------------------------------------------------------------
// One byte beat is taken every clock cycle while the output can drain; its
// result beat appears in the next cycle from a single output register, and a
// new input beat is taken whenever that register is empty or being drained in
// the same cycle. The last eight captured bytes sit in a row of eight byte
// cells that shift once per captured beat, and header and CR LF checks look
// at that row plus the incoming byte, so the frame position counter is the
// only loop. capture_enable is written through the cfg channel, always ready.
// ----------------------------------------------------------------------------
module ipd_header_and_crlf_framer #(
    parameter int unsigned FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: capture_enable
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [13:8] write_index,
                                        // [14] header_seen, [20:15] line_length,
                                        // [21] frame_full, [22] frame_ok, [23] zero
    output logic        m_axis_tuser    // [0] captured
);
    import ihcf_pkg::*;

    logic        r_cap;
    logic        r_valid;
    logic [23:0] r_data;
    logic        r_user;
    logic [23:0] n_data;

    logic        w_in_acc;
    logic        w_shift;
    logic [7:0]  w_win [WIN_BYTES];
    logic [HDR_LEN-1:0] w_hdr_eq;
    t_match      w_match;
    t_frame_res  w_res;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_shift       = w_in_acc && r_cap;
    assign o_cfg_ready   = 1'b1;

    genvar g;
    generate
        for (g = 0; g < WIN_BYTES; g++) begin : g_cell
            if (g == WIN_BYTES - 1) begin : g_tail
                ihcf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_byte  (s_axis_tdata),
                    .o_byte  (w_win[g])
                );
            end else begin : g_body
                ihcf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_byte  (w_win[g+1]),
                    .o_byte  (w_win[g])
                );
            end
        end
    endgenerate

    // compare the window as it stands after this beat's shift
    always_comb begin
        for (int k = 0; k < HDR_LEN; k++) begin
            w_hdr_eq[k] = (w_win[k+1] == HDR_PAT[k]);
        end
        w_match.header_hit = &w_hdr_eq;
        w_match.tail_crlf  = (w_win[WIN_BYTES-1] == CH_CR) && (s_axis_tdata == CH_LF);
    end

    ihcf_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_shift),
        .i_match   (w_match),
        .o_res     (w_res)
    );

    always_comb begin
        n_data = {1'b0, 23'd0};
        n_data[7:0] = s_axis_tdata;
        if (r_cap) begin
            n_data[13:8]  = w_res.write_index;
            n_data[14]    = w_res.header_seen;
            n_data[20:15] = w_res.line_length;
            n_data[21]    = w_res.frame_full;
            n_data[22]    = w_res.frame_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data <= n_data;
            r_user <= r_cap;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_user;

endmodule

[rtl/core/ihcf_checker.sv]
// ----------------------------------------------------------------------------
// ihcf_checker
// Port-level checks on the framer, bound to the top level.
// ----------------------------------------------------------------------------
module ihcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // the input side never waits while the output register can drain
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free output register");

    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=>
            m_axis_tvalid && m_axis_tdata[7:0] == $past(s_axis_tdata))
        else $error("result beat does not echo the accepted byte");

    a_cmd_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("command byte carries framing fields");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[14] || !m_axis_tdata[21]) |->
            !m_axis_tdata[22] && (!m_axis_tdata[14] ||
            (m_axis_tdata[20:15] == 6'd0 && !m_axis_tdata[21])))
        else $error("framing events overlap");

endmodule

bind ipd_header_and_crlf_framer ihcf_checker u_ihcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[bench/ipd_header_and_crlf_framer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_header_and_crlf_framer_tb
// Drives byte beats into the framer with random gaps and output stalls, and
// keeps its own model of the frame window, position and capture setting.
// Each result beat is checked field by field against the oldest predicted
// beat. Covers pass-through, "+IPD," headers, CR LF lines, full frames and
// a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module ipd_header_and_crlf_framer_tb;

    import ihcf_pkg::CH_CR;
    import ihcf_pkg::CH_LF;

    localparam int unsigned FRAME_LEN   = 64;
    localparam int unsigned WIN_LEN     = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_PCT    = 32;
    // "+IPD," with the first character in the low byte
    localparam logic [39:0] IPD_TAG     = {8'h2C, 8'h44, 8'h50, 8'h49, 8'h2B};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       captured;
        logic [5:0] write_index;
        logic       header_seen;
        logic [5:0] line_length;
        logic       frame_full;
        logic       frame_ok;
    } framer_beat_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [7:0] data_byte, [13:8] write_index, [14] header_seen,
                                  // [20:15] line_length, [21] frame_full, [22] frame_ok
    logic        m_axis_tuser;    // [0] captured

    // model state
    logic [7:0]   win_bytes [WIN_LEN];
    int unsigned  frame_pos;
    logic         capture_on;

    framer_beat_t expected_beats [$];
    int           items_sent;
    int           mismatches;
    int unsigned  cycle_count;
    bit           steady;
    int           hold_requests;
    int           hold_served;
    int unsigned  hold_left;

    ipd_header_and_crlf_framer #(
        .FRAME_BYTES (FRAME_LEN)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Work out the result beat for one accepted byte and advance the model.
    function automatic framer_beat_t frame_byte(input logic [7:0] rx);
        framer_beat_t beat;
        int unsigned  wi;
        int           k;
        beat = '0;
        beat.data_byte = rx;
        if (!capture_on)
            return beat;
        wi = frame_pos;
        for (k = 0; k < WIN_LEN - 1; k++)
            win_bytes[k] = win_bytes[k + 1];
        win_bytes[WIN_LEN - 1] = rx;
        frame_pos = frame_pos + 1;
        if (frame_pos >= WIN_LEN &&
            {win_bytes[4], win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]} == IPD_TAG) begin
            beat.header_seen = 1'b1;
            frame_pos = 0;
        end
        if (frame_pos >= 2 && frame_pos < FRAME_LEN &&
            win_bytes[6] == CH_CR && win_bytes[7] == CH_LF) begin
            beat.line_length = frame_pos[5:0];
            frame_pos = 0;
        end
        if (frame_pos >= FRAME_LEN) begin
            beat.frame_full = 1'b1;
            beat.frame_ok   = (win_bytes[6] == CH_CR && win_bytes[7] == CH_LF);
            frame_pos = 0;
        end
        beat.captured    = 1'b1;
        beat.write_index = wi[5:0];
        return beat;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        framer_beat_t got;
        framer_beat_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data_byte   = m_axis_tdata[7:0];
            got.write_index = m_axis_tdata[13:8];
            got.header_seen = m_axis_tdata[14];
            got.line_length = m_axis_tdata[20:15];
            got.frame_full  = m_axis_tdata[21];
            got.frame_ok    = m_axis_tdata[22];
            got.captured    = m_axis_tuser;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: data %02h", got.data_byte);
            end else begin
                want = expected_beats.pop_front();
                if (got.data_byte != want.data_byte || got.captured != want.captured ||
                    got.write_index != want.write_index ||
                    got.header_seen != want.header_seen ||
                    got.line_length != want.line_length ||
                    got.frame_full != want.frame_full || got.frame_ok != want.frame_ok ||
                    m_axis_tdata[23] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp data %02h cap %0d idx %0d hdr %0d line %0d ",
                                  "full %0d ok %0d / got data %02h cap %0d idx %0d hdr %0d ",
                                  "line %0d full %0d ok %0d pad %0d"},
                                 want.data_byte, want.captured, want.write_index,
                                 want.header_seen, want.line_length, want.frame_full,
                                 want.frame_ok, got.data_byte, got.captured,
                                 got.write_index, got.header_seen, got.line_length,
                                 got.frame_full, got.frame_ok, m_axis_tdata[23]);
                end
            end
        end
    end

    // Output side: random stalls, a steady stretch, and hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_beats.push_back(frame_byte(b));
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // random byte that is never LF, so no stray line end appears
    task automatic send_filler(input int n);
        int      i;
        logic [7:0] b;
        for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF)
                b = 8'hFF;
            send_byte(b);
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capture(input logic en);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        capture_on = en;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // fill the rest of the current frame, ending in CR LF or not
    task automatic complete_frame(input bit with_crlf);
        int n;
        n = FRAME_LEN - frame_pos;
        if (n >= 2) begin
            send_filler(n - 2);
            if (with_crlf) begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else begin
                send_filler(2);
            end
        end else begin
            send_filler(n);
        end
    endtask

    task automatic test_passthrough;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("+IPD,");
    endtask

    task automatic test_headers;
        // header whose last byte is CR, then LF at position one: no line
        send_text("+IPD,ab");
        send_byte(CH_CR);
        send_byte(CH_LF);
        // header ending in '+', then a pattern that sits in a frame too short
        send_text("+IPD,ab+");
        send_text("IPD,abc");
        send_byte(CH_CR);
        send_byte(CH_LF);
        // header and CR LF land on the same beat: header wins
        send_text("+IPD,x");
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_lines_and_frames;
        send_byte(CH_CR);
        send_byte(CH_LF);
        complete_frame(1'b1);
        complete_frame(1'b0);
        send_filler(FRAME_LEN - 3);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_random_traffic(input int n_items);
        int start;
        int kind;
        int len;
        int i;
        start = items_sent;
        while (items_sent - start < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                send_text("+IPD,");
                send_filler($urandom_range(0, 20));
                if ($urandom_range(0, 1)) begin
                    send_byte(CH_CR);
                    send_byte(CH_LF);
                end
            end else if (kind <= 5) begin
                send_filler($urandom_range(0, 30));
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else if (kind == 6) begin
                complete_frame(1'($urandom_range(0, 1)));
            end else if (kind == 7) begin
                // broken header
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    send_byte(IPD_TAG[8*i +: 8]);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_backpressure;
        steady = 1'b1;
        hold_requests++;
        send_filler(40);
        send_byte(CH_CR);
        send_byte(CH_LF);
        steady = 1'b0;
    endtask

    initial begin
        int k;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        cycle_count   = 0;
        items_sent    = 0;
        mismatches    = 0;
        steady        = 1'b0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        for (k = 0; k < WIN_LEN; k++)
            win_bytes[k] = 8'h00;
        frame_pos  = 0;
        capture_on = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        write_capture(1'b1);
        test_headers();
        test_lines_and_frames();
        test_random_traffic(120);
        write_capture(1'b0);
        test_random_traffic(40);
        write_capture(1'b1);
        steady = 1'b1;
        test_random_traffic(60);
        steady = 1'b0;
        test_random_traffic(80);
        test_backpressure();
        drain();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
